// ===== design/lsb_first_bit_packer_unit_assert.svh =====
// Assertion macros shared by the bit packer modules.
`ifndef LSB_FIRST_BIT_PACKER_UNIT_ASSERT_SVH
`define LSB_FIRST_BIT_PACKER_UNIT_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define LSBP_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("lsbp: invariant violated");

// The consequent must hold in the cycle after the antecedent.
`define LSBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lsbp: sequence check failed");

`endif

// ===== design/lsbp_pkg.sv =====
// Types and constants of the LSB-first bit packer.
`timescale 1ns / 1ps
package lsbp_pkg;

  localparam int unsigned ACC_BITS  = 16;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned MAX_BYTES = 6;
  localparam int unsigned CNT_W     = $clog2(ACC_BITS + 1);
  localparam int unsigned NUM_W     = $clog2(MAX_BYTES + 1);

  typedef enum logic [1:0] {
    CMD_SEND   = 2'd0,
    CMD_FLUSH  = 2'd1,
    CMD_HEADER = 2'd2,
    CMD_RAW    = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] code_value;
    logic [4:0]  code_length;
    logic [15:0] block_length;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [NUM_W-1:0]               count;
    logic [MAX_BYTES*BYTE_BITS-1:0] bytes;
  } batch_t;

endpackage

// ===== design/lsbp_item_if.sv =====
// Valid/ready channel that carries one packer command item.
`timescale 1ns / 1ps
interface lsbp_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] code_value;
  logic [4:0]  code_length;
  logic [15:0] block_length;
  logic [7:0]  data_byte;

  modport source (
    output valid, cmd, code_value, code_length, block_length, data_byte,
    input  ready
  );
  modport sink (
    input  valid, cmd, code_value, code_length, block_length, data_byte,
    output ready
  );
endinterface

// ===== design/lsbp_byte_if.sv =====
// Valid/ready channel that carries one output byte and its last flag.
`timescale 1ns / 1ps
interface lsbp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (
    output valid, out_byte, last,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last,
    output ready
  );
endinterface

// ===== design/lsbp_pack.sv =====
// Bit accumulator state and the byte batch that one command item produces.
`timescale 1ns / 1ps
`include "lsb_first_bit_packer_unit_assert.svh"
module lsbp_pack (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lsbp_pkg::item_t item_i,
  input  logic            take_i,
  output lsbp_pkg::batch_t batch_o
);
  import lsbp_pkg::*;

  logic [ACC_BITS-1:0]   acc_q, acc_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      len;
  logic [ACC_BITS:0]     mask;
  logic [ACC_BITS-1:0]   masked;
  logic [CNT_W:0]        sum;
  logic                  ovf;
  logic [2*ACC_BITS-1:0] merged;
  logic [1:0]            fcnt;
  logic [ACC_BITS-1:0]   fvec;
  logic [31:0]           ext;
  logic [NUM_W-1:0]      ecnt;
  logic [MAX_BYTES*BYTE_BITS-1:0] tail;

  always_comb begin
    len    = (item_i.code_length > CNT_W'(ACC_BITS)) ? CNT_W'(ACC_BITS) : item_i.code_length;
    mask   = ((ACC_BITS+1)'(1) << len) - (ACC_BITS+1)'(1);
    masked = item_i.code_value & mask[ACC_BITS-1:0];
    sum    = {1'b0, cnt_q} + {1'b0, len};
    ovf    = sum > (CNT_W+1)'(ACC_BITS);
    merged = {{ACC_BITS{1'b0}}, acc_q} | ({{ACC_BITS{1'b0}}, masked} << cnt_q);

    // Pending bits go out as one or two bytes ahead of any aligned bytes.
    if (cnt_q > CNT_W'(BYTE_BITS)) begin
      fcnt = 2'd2;
    end else if (cnt_q != '0) begin
      fcnt = 2'd1;
    end else begin
      fcnt = 2'd0;
    end
    fvec = acc_q;

    ext  = '0;
    ecnt = '0;
    case (item_i.cmd)
      CMD_HEADER: begin
        ext  = {~item_i.block_length, item_i.block_length};
        ecnt = NUM_W'(4);
      end
      CMD_RAW: begin
        ext  = {24'd0, item_i.data_byte};
        ecnt = NUM_W'(1);
      end
      default: begin
        ext  = '0;
        ecnt = '0;
      end
    endcase
    tail = ({16'd0, ext} << {fcnt, 3'b000}) | {32'd0, fvec};

    acc_d = acc_q;
    cnt_d = cnt_q;
    batch_o.count = '0;
    batch_o.bytes = tail;
    case (item_i.cmd)
      CMD_SEND: begin
        batch_o.bytes = {32'd0, merged[ACC_BITS-1:0]};
        if (ovf) begin
          batch_o.count = NUM_W'(2);
          acc_d = merged[2*ACC_BITS-1:ACC_BITS];
          cnt_d = CNT_W'(sum - (CNT_W+1)'(ACC_BITS));
        end else begin
          acc_d = merged[ACC_BITS-1:0];
          cnt_d = sum[CNT_W-1:0];
        end
      end
      CMD_FLUSH, CMD_HEADER, CMD_RAW: begin
        batch_o.count = {1'b0, fcnt} + ecnt;
        acc_d = '0;
        cnt_d = '0;
      end
      default: begin
        batch_o.count = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (take_i) begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  `LSBP_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CNT_W'(ACC_BITS))
  `LSBP_ASSERT_ALWAYS(a_acc_clean, (cnt_q >= CNT_W'(ACC_BITS)) || ((acc_q >> cnt_q) == '0))
  `LSBP_ASSERT_NEXT(a_state_held, !take_i, $stable(acc_q) && $stable(cnt_q))

endmodule

// ===== design/lsb_first_bit_packer_unit.sv =====
// LSB-first bit packer: command items in, output bytes out, last byte of each item flagged.
// An item's bytes pass through the item, batch and output byte registers.
// Throughput: one item per cycle for items without bytes, else one byte per cycle while
// the output is ready; the next item is taken as the last byte of a batch pops.
// Reset clears the accumulator, the bit count and all valid flags; no clearing pass.
`timescale 1ns / 1ps
`include "lsb_first_bit_packer_unit_assert.svh"
module lsb_first_bit_packer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsbp_item_if.sink   in_i,
  lsbp_byte_if.source out_o
);
  import lsbp_pkg::*;

  logic                           in_vld_q;
  item_t                          item_q;
  logic                           process;
  batch_t                         batch;
  logic [NUM_W-1:0]               bat_cnt_q;
  logic [MAX_BYTES*BYTE_BITS-1:0] bat_bytes_q;
  logic                           pop;
  logic                           bat_free;
  logic                           out_vld_q;
  logic [BYTE_BITS-1:0]           out_byte_q;
  logic                           out_last_q;
  logic                           out_free;

  assign out_free = !out_vld_q || out_o.ready;
  assign pop      = (bat_cnt_q != '0) && out_free;
  assign bat_free = (bat_cnt_q == '0) || ((bat_cnt_q == NUM_W'(1)) && pop);
  assign process  = in_vld_q && bat_free;
  assign in_i.ready = !in_vld_q || process;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.cmd          <= cmd_e'(in_i.cmd);
      item_q.code_value   <= in_i.code_value;
      item_q.code_length  <= in_i.code_length;
      item_q.block_length <= in_i.block_length;
      item_q.data_byte    <= in_i.data_byte;
    end
  end

  lsbp_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_q),
    .take_i  (process),
    .batch_o (batch)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bat_cnt_q <= '0;
    end else if (process) begin
      bat_cnt_q <= batch.count;
    end else if (pop) begin
      bat_cnt_q <= bat_cnt_q - NUM_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      bat_bytes_q <= batch.bytes;
    end else if (pop) begin
      bat_bytes_q <= bat_bytes_q >> BYTE_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pop) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_byte_q <= bat_bytes_q[BYTE_BITS-1:0];
      out_last_q <= (bat_cnt_q == NUM_W'(1));
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last     = out_last_q;

  `LSBP_ASSERT_NEXT(a_last_on_final, pop && (bat_cnt_q == NUM_W'(1)), out_vld_q && out_last_q)
  `LSBP_ASSERT_NEXT(a_no_early_last, pop && (bat_cnt_q > NUM_W'(1)), out_vld_q && !out_last_q)
  `LSBP_ASSERT_NEXT(a_item_held, in_vld_q && !process, in_vld_q)

endmodule
